// ===== rtl/rtki_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtki_pkg
// Shared types, codes and the rank compare of the ranked top-k hit list.
// ----------------------------------------------------------------------------
package rtki_pkg;

    // Request codes carried in s_tuser
    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DUMP   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    // Result codes carried in m_tuser
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_CLEARED   = 3'd3,
        ST_DUMP      = 3'd4
    } status_t;

    // Most entries one dump emits
    localparam int MAX_DUMP = 16;

    typedef struct packed {
        logic [31:0] rec;
        logic [31:0] lon;
        logic [31:0] lat;
        logic [63:0] name_key;
        logic [6:0]  name_len;
        logic [7:0]  prio;
        logic [1:0]  score;
    } entry_t;

    // True when hit a sorts strictly ahead of held entry b
    function automatic logic ranks_before(input entry_t a, input entry_t b);
        logic r;
        if (a.score != b.score) begin
            r = a.score < b.score;
        end else if (a.prio != b.prio) begin
            r = a.prio < b.prio;
        end else begin
            r = a.name_len < b.name_len;
        end
        return r;
    endfunction

    // Same name and bit-identical coordinates
    function automatic logic same_place(input entry_t a, input entry_t b);
        return (a.name_key == b.name_key) && (a.lat == b.lat) && (a.lon == b.lon);
    endfunction

endpackage

// ===== rtl/rtki_entry_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtki_entry_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rtki_entry_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  rtki_pkg::entry_t wr_data,
    input  logic [AW-1:0]    rd_addr,
    output rtki_pkg::entry_t rd_data
);

    rtki_pkg::entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/ranked_top_k_insert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ranked_top_k_insert
// Bounded list of search hits sorted by score, priority and name length.
// ----------------------------------------------------------------------------
// The hits live in one single-port-read, single-port-write memory and the block
// works on one request at a time; s_tready is high only while it waits for a
// request. An insert walks the held entries one per cycle through the memory
// read port, looking for a duplicate (answered with ST_DUPLICATE) and the
// insertion slot; a hit that ranks behind every entry of a full list is
// dropped. Otherwise it moves each entry behind that slot up by one, one per
// cycle (the last entry of a full list falls off), writes the new hit and
// returns its status. A dump emits one word per cycle while m_tready allows,
// the last one flagged with m_tlast; an empty list gives no word.
// Results sit in an output register, so a stalled m_tready only holds the
// block, it loses nothing. The memory needs no clearing after reset: only
// entries below the held count are ever used.
// ----------------------------------------------------------------------------
module ranked_top_k_insert #(
    parameter int LIST_DEPTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // score[1:0], priority_req[9:2], name_length[16:10], name_key[80:17],
    // latitude_bits[112:81], longitude_bits[144:113], record_id[176:145]
    input  logic [183:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // position[3:0], entry_record[35:4], entry_score[37:36],
    // entry_priority[45:38], entry_latitude[77:46], entry_longitude[109:78]
    output logic [111:0] m_tdata,
    // status[2:0]
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int WW = CW + 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PLACE,
        S_RESP,
        S_DUMP
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       held_reg, held_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic                found_reg, found_next;
    rtki_pkg::entry_t    req_reg, req_next;
    rtki_pkg::status_t   status_reg, status_next;

    logic                m_valid_reg, m_valid_next;
    logic [3:0]          m_pos_reg, m_pos_next;
    rtki_pkg::entry_t    m_entry_reg, m_entry_next;
    rtki_pkg::status_t   m_status_reg, m_status_next;
    logic                m_last_reg, m_last_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    rtki_pkg::entry_t    mem_wdata;
    logic [AW-1:0]       mem_raddr;
    rtki_pkg::entry_t    rd_q;

    logic                out_free;
    logic [CW-1:0]       cnt_grow;
    logic [WW-1:0]       idx_w;
    logic                dump_last;
    rtki_pkg::entry_t    in_entry;
    rtki_pkg::mode_t     in_mode;

    function automatic logic [3:0] pos4(input logic [CW-1:0] v);
        logic [CW+3:0] w;
        w = {4'b0000, v};
        return w[3:0];
    endfunction

    assign in_mode           = rtki_pkg::mode_t'(s_tuser);
    assign in_entry.score    = s_tdata[1:0];
    assign in_entry.prio     = s_tdata[9:2];
    assign in_entry.name_len = s_tdata[16:10];
    assign in_entry.name_key = s_tdata[80:17];
    assign in_entry.lat      = s_tdata[112:81];
    assign in_entry.lon      = s_tdata[144:113];
    assign in_entry.rec      = s_tdata[176:145];

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign cnt_grow = (held_reg < CW'(LIST_DEPTH)) ? held_reg + 1'b1 : held_reg;
    assign idx_w    = WW'(idx_reg);
    assign dump_last = (idx_w + 1'b1 == WW'(held_reg)) || (idx_w == WW'(rtki_pkg::MAX_DUMP - 1));

    always_comb begin
        state_next    = state_reg;
        held_next     = held_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        found_next    = found_reg;
        req_next      = req_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg;
        m_pos_next    = m_pos_reg;
        m_entry_next  = m_entry_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg[AW-1:0];
        mem_wdata     = rd_q;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_next = in_entry;
                    case (in_mode)
                        rtki_pkg::MODE_CLEAR: begin
                            held_next   = '0;
                            pos_next    = '0;
                            status_next = rtki_pkg::ST_CLEARED;
                            state_next  = S_RESP;
                        end
                        rtki_pkg::MODE_INSERT: begin
                            idx_next   = '0;
                            found_next = 1'b0;
                            pos_next   = held_reg;
                            state_next = S_SCAN;
                        end
                        rtki_pkg::MODE_DUMP: begin
                            if (held_reg != '0) begin
                                idx_next   = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // rd_q holds the entry at idx_reg
                if (idx_reg == held_reg) begin
                    if (pos_reg >= CW'(LIST_DEPTH)) begin
                        pos_next    = '0;
                        status_next = rtki_pkg::ST_DROPPED;
                        state_next  = S_RESP;
                    end else begin
                        held_next = cnt_grow;
                        if (cnt_grow > pos_reg + 1'b1) begin
                            idx_next   = cnt_grow - CW'(2);
                            state_next = S_SHIFT;
                        end else begin
                            state_next = S_PLACE;
                        end
                    end
                end else if (rtki_pkg::same_place(req_reg, rd_q)) begin
                    pos_next    = idx_reg;
                    status_next = rtki_pkg::ST_DUPLICATE;
                    state_next  = S_RESP;
                end else begin
                    if (!found_reg && rtki_pkg::ranks_before(req_reg, rd_q)) begin
                        pos_next   = idx_reg;
                        found_next = 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SHIFT: begin
                // move entry idx up one slot while the next one is read
                mem_we    = 1'b1;
                mem_waddr = AW'(idx_reg + 1'b1);
                mem_wdata = rd_q;
                if (idx_reg == pos_reg) begin
                    state_next = S_PLACE;
                end else begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_PLACE: begin
                mem_we      = 1'b1;
                mem_waddr   = pos_reg[AW-1:0];
                mem_wdata   = req_reg;
                status_next = rtki_pkg::ST_INSERTED;
                state_next  = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_pos_next    = pos4(pos_reg);
                    m_entry_next  = '0;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = rtki_pkg::ST_DUMP;
                    m_pos_next    = pos4(idx_reg);
                    m_entry_next  = rd_q;
                    m_last_next   = dump_last;
                    if (dump_last) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // read follows the next index so rd_q tracks idx_reg while it is below LIST_DEPTH
    assign mem_raddr = (idx_next < CW'(LIST_DEPTH)) ? idx_next[AW-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        found_reg    <= found_next;
        req_reg      <= req_next;
        status_reg   <= status_next;
        m_pos_reg    <= m_pos_next;
        m_entry_reg  <= m_entry_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    rtki_entry_ram #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (rd_q)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_entry_reg.lon, m_entry_reg.lat, m_entry_reg.prio,
                       m_entry_reg.score, m_entry_reg.rec, m_pos_reg};

`ifndef NO_ASSERTIONS
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CW'(LIST_DEPTH))
        else $error("held count above list depth");

    a_insert_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == rtki_pkg::MODE_INSERT) |=> state_reg == S_SCAN)
        else $error("insert did not start a scan");

    a_place_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PLACE || state_reg == S_SHIFT) |-> pos_reg < CW'(LIST_DEPTH))
        else $error("insert slot past end of list");

    a_single_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != rtki_pkg::ST_DUMP) |-> m_tlast)
        else $error("status word without last flag");

    a_shift_within: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SHIFT |-> (idx_reg + 1'b1 < held_reg && idx_reg >= pos_reg))
        else $error("shift index outside held range");
`endif

endmodule
